FILE: sv/otsp_pkg.sv
package otsp_pkg;

  localparam int AXES   = 4;
  localparam int TW     = 22;
  localparam int SW     = 19;
  localparam int QW     = 18;
  localparam int NW     = 44;
  localparam int DW     = 24;
  localparam int FW     = 9;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_TX   = 3'd0;
  localparam logic [2:0] REG_TY   = 3'd1;
  localparam logic [2:0] REG_TT   = 3'd2;
  localparam logic [2:0] REG_TH   = 3'd3;
  localparam logic [2:0] REG_SP   = 3'd4;
  localparam logic [2:0] REG_RAMP = 3'd5;

  localparam logic [9:0] SP_RESET = 10'd100;

endpackage

FILE: sv/otsp_in_if.sv
interface otsp_in_if;
  logic                       valid;
  logic                       ready;
  logic [otsp_pkg::TW-1:0]    tick_count;

  modport source (output valid, output tick_count, input ready);
  modport sink   (input valid, input tick_count, output ready);
endinterface

FILE: sv/otsp_out_if.sv
interface otsp_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [otsp_pkg::SW-1:0] speed_x;
  logic signed [otsp_pkg::SW-1:0] speed_y;
  logic signed [otsp_pkg::SW-1:0] speed_turn;
  logic signed [otsp_pkg::SW-1:0] speed_heading;
  logic [otsp_pkg::TW-1:0]        total_ticks;
  logic                           move_done;

  modport source (output valid, output speed_x, output speed_y, output speed_turn,
                  output speed_heading, output total_ticks, output move_done,
                  input ready);
  modport sink   (input valid, input speed_x, input speed_y, input speed_turn,
                  input speed_heading, input total_ticks, input move_done,
                  output ready);
endinterface

FILE: sv/omni_trapezoid_speed_profile_top.sv
// Trapezoidal speed profile for a four-axis omni drive. Targets, top speed and
// ramp code are written over the APB port; after reset and after every write the
// block derives the move constants (peak magnitude, total tick count through a
// one-bit-per-cycle divider) and holds in_s.ready low meanwhile. Afterwards it
// takes one tick count per cycle while the output is not stalled; each beat goes
// through a pipeline (input register, ramp factor, multiply, 18 restoring divide
// stages, sign and output register). A stall on the output freezes the whole
// pipeline.
module omni_trapezoid_speed_profile_top (
  input  logic                          clk,
  input  logic                          rst_n,
  otsp_in_if.sink                       in_s,
  otsp_out_if.source                    out_s,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [otsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AXES = otsp_pkg::AXES;
  localparam int TW   = otsp_pkg::TW;
  localparam int SW   = otsp_pkg::SW;
  localparam int QW   = otsp_pkg::QW;
  localparam int NW   = otsp_pkg::NW;
  localparam int DW   = otsp_pkg::DW;
  localparam int FW   = otsp_pkg::FW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [4:0] DIV_LAST = 5'(TW - 1);

  // registers
  logic signed [15:0] tgt_r [AXES];
  logic [9:0]         sp_r;
  logic signed [8:0]  code_r;
  logic               wr;
  logic [2:0]         widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) tgt_r[i] <= '0;
      sp_r   <= otsp_pkg::SP_RESET;
      code_r <= '0;
    end else if (wr) begin
      case (widx)
        otsp_pkg::REG_TX:   tgt_r[0] <= pwdata[15:0];
        otsp_pkg::REG_TY:   tgt_r[1] <= pwdata[15:0];
        otsp_pkg::REG_TT:   tgt_r[2] <= pwdata[15:0];
        otsp_pkg::REG_TH:   tgt_r[3] <= pwdata[15:0];
        otsp_pkg::REG_SP:   sp_r     <= pwdata[9:0];
        otsp_pkg::REG_RAMP: code_r   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      otsp_pkg::REG_TX:   prdata = 32'(tgt_r[0]);
      otsp_pkg::REG_TY:   prdata = 32'(tgt_r[1]);
      otsp_pkg::REG_TT:   prdata = 32'(tgt_r[2]);
      otsp_pkg::REG_TH:   prdata = 32'(tgt_r[3]);
      otsp_pkg::REG_SP:   prdata = {22'd0, sp_r};
      otsp_pkg::REG_RAMP: prdata = 32'(code_r);
      default:            prdata = '0;
    endcase
  end

  // move constants
  logic [1:0]         state_r, state_nxt;
  logic [4:0]         cnt_r;
  logic [25:0]        magsp_r [AXES];
  logic               neg_r [AXES];
  logic [DW-1:0]      den_r;
  logic [FW-1:0]      len_r, lenf_r;
  logic               up_r, down_r, zero_r;
  logic signed [9:0]  allow_r;
  logic [TW-1:0]      dvd_r, quo_r, total_r;
  logic [9:0]         dsor_r, rem_r;
  logic signed [DW-1:0] thr_r;

  logic [15:0]        mg [AXES];
  logic [15:0]        peak;
  logic [9:0]         spe;
  logic [FW-1:0]      len;
  logic               gt100;
  logic [10:0]        trial;
  logic signed [DW-1:0] total_s;

  always_comb begin
    peak = '0;
    for (int i = 0; i < AXES; i++) begin
      mg[i] = tgt_r[i][15] ? 16'(-tgt_r[i]) : 16'(tgt_r[i]);
      if (mg[i] > peak) peak = mg[i];
    end
    spe   = (sp_r == 10'd0) ? 10'd1 : sp_r;
    gt100 = code_r > 9'sd100;
    if (gt100)          len = 9'(code_r - 9'sd100);
    else if (code_r[8]) len = 9'(-code_r);
    else                len = code_r[8:0];
    trial   = {rem_r, dvd_r[TW-1]};
    total_s = DW'($signed({2'b00, quo_r})) + DW'(allow_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (wr) state_nxt = ST_PREP;
      ST_PREP: state_nxt = wr ? ST_PREP : ST_DIV;
      ST_DIV:  if (wr) state_nxt = ST_PREP;
               else if (cnt_r == DIV_LAST) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = wr ? ST_PREP : ST_IDLE;
      default: state_nxt = ST_PREP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_PREP;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_PREP: begin
        for (int i = 0; i < AXES; i++) begin
          magsp_r[i] <= 26'(mg[i]) * 26'(spe);
          neg_r[i]   <= (i < 2) ? tgt_r[i][15] : (!tgt_r[i][15] && tgt_r[i] != 16'sd0);
        end
        len_r   <= len;
        lenf_r  <= (len == '0) ? 9'd1 : len;
        den_r   <= DW'(peak) * DW'((len == '0) ? 9'd1 : len);
        up_r    <= !code_r[8] && code_r != 9'sd0;
        down_r  <= gt100 || code_r[8];
        zero_r  <= peak == 16'd0;
        allow_r <= (code_r < 9'sd100 && code_r != 9'sd0) ? $signed({2'b00, len[8:1]})
                                                          : $signed({1'b0, len}) - 10'sd1;
        dvd_r   <= TW'(32'(peak) * 32'd100 + 32'(spe) - 32'd1);
        dsor_r  <= spe;
        rem_r   <= '0;
        cnt_r   <= '0;
      end
      ST_DIV: begin
        if (trial >= {1'b0, dsor_r}) begin
          rem_r <= 10'(trial - {1'b0, dsor_r});
          quo_r <= {quo_r[TW-2:0], 1'b1};
        end else begin
          rem_r <= trial[9:0];
          quo_r <= {quo_r[TW-2:0], 1'b0};
        end
        dvd_r <= {dvd_r[TW-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
      end
      ST_FIN: begin
        total_r <= zero_r ? '0 : (total_s[DW-1] ? '0 : total_s[TW-1:0]);
        thr_r   <= (zero_r ? '0 : (total_s[DW-1] ? '0 : DW'($signed({2'b00, total_s[TW-1:0]}))))
                   - DW'($signed({1'b0, len_r})) + DW'(1);
      end
      default: ;
    endcase
  end

  // pipeline
  logic en;
  assign en         = !out_s.valid || out_s.ready;
  assign in_s.ready = en && (state_r == ST_IDLE);

  logic            s0_v_r, s1_v_r;
  logic [TW-1:0]   s0_tick_r;
  logic [FW-1:0]   s1_f_r;
  logic            s1_done_r;
  logic            ramp_up, down_hit;
  logic signed [DW-1:0] tick_s, remt;
  logic [FW-1:0]   f;

  always_comb begin
    tick_s   = DW'($signed({1'b0, s0_tick_r}));
    remt     = DW'($signed({2'b00, total_r})) - tick_s;
    ramp_up  = up_r && (s0_tick_r < TW'(len_r));
    down_hit = down_r && (len_r != '0) && (tick_s >= thr_r);
    if (down_hit)     f = remt[DW-1] ? '0 : remt[FW-1:0];
    else if (ramp_up) f = FW'(s0_tick_r) + FW'(1);
    else              f = lenf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_s.valid && in_s.ready;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tick_r <= in_s.tick_count;
      s1_f_r    <= f;
      s1_done_r <= s0_tick_r > total_r;
    end
  end

  logic [NW-1:0] drem_r [QW+1][AXES];
  logic [QW-1:0] dq_r   [QW+1][AXES];
  logic          dv_r   [QW+1];
  logic          dd_r   [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0] <= s1_done_r;
      for (int i = 0; i < AXES; i++) begin
        drem_r[0][i] <= NW'({35'(magsp_r[i]) * 35'(s1_f_r), 8'd0});
        dq_r[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = QW - 1 - k;
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (en) dv_r[k+1] <= dv_r[k];
    end
    for (genvar a = 0; a < AXES; a++) begin : g_lane
      logic [NW-1:0] dsh;
      assign dsh = NW'(den_r) << J;
      always_ff @(posedge clk) begin
        if (en) begin
          if (drem_r[k][a] >= dsh) begin
            drem_r[k+1][a] <= drem_r[k][a] - dsh;
            dq_r[k+1][a]   <= dq_r[k][a] | (QW'(1) << J);
          end else begin
            drem_r[k+1][a] <= drem_r[k][a];
            dq_r[k+1][a]   <= dq_r[k][a];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dd_r[k+1] <= dd_r[k];
    end
  end

  logic                 out_valid_r;
  logic signed [SW-1:0] spd_r [AXES];
  logic [TW-1:0]        total_o_r;
  logic                 done_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        if (zero_r)        spd_r[i] <= '0;
        else if (neg_r[i]) spd_r[i] <= -$signed({1'b0, dq_r[QW][i]});
        else               spd_r[i] <= $signed({1'b0, dq_r[QW][i]});
      end
      total_o_r <= total_r;
      done_o_r  <= dd_r[QW];
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.speed_x       = spd_r[0];
  assign out_s.speed_y       = spd_r[1];
  assign out_s.speed_turn    = spd_r[2];
  assign out_s.speed_heading = spd_r[3];
  assign out_s.total_ticks   = total_o_r;
  assign out_s.move_done     = done_o_r;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_s.ready) else $error("ready while deriving constants");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST)) else $error("divider count overrun");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !wr) |=> (state_r == ST_IDLE)) else $error("no return to idle");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> s0_v_r) else $error("accepted beat dropped");

endmodule
